/* src/line_follower_mode_controller_assert.svh */
// Assertion macros used by the line follower top level.
`ifndef LINE_FOLLOWER_MODE_CONTROLLER_ASSERT_SVH
`define LINE_FOLLOWER_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define LFMC_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define LFMC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

/* src/lfmc_pkg.sv */
// Shared types and constants of the line follower mode controller.
package lfmc_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int THRESH_BITS    = 10;
    localparam int SPEED_BITS     = 7;
    localparam int TICK_BITS      = 8;
    localparam int POWER_BITS     = 8;
    localparam int MODE_BITS      = 3;
    localparam int TURN_CNT_BITS  = TICK_BITS + 1;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 10;
    localparam int CMP_BITS       = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    localparam logic [THRESH_BITS-1:0] DARK_LEVEL_RST   = THRESH_BITS'(500);
    localparam logic [THRESH_BITS-1:0] MATCH_MARGIN_RST = THRESH_BITS'(100);
    localparam logic [SPEED_BITS-1:0]  DRIVE_SPEED_RST  = SPEED_BITS'(35);
    localparam logic [TICK_BITS-1:0]   TURN_TICKS_RST   = TICK_BITS'(20);
    localparam logic [TICK_BITS-1:0]   BLINK_TICKS_RST  = TICK_BITS'(5);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_SEARCH      = 3'd0,
        MODE_FOLLOW      = 3'd1,
        MODE_CHECK_LEFT  = 3'd2,
        MODE_CHECK_RIGHT = 3'd3,
        MODE_DONE        = 3'd4
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DARK_LEVEL   = 3'd0,
        CFG_MATCH_MARGIN = 3'd1,
        CFG_DRIVE_SPEED  = 3'd2,
        CFG_TURN_TICKS   = 3'd3,
        CFG_BLINK_TICKS  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] dark_level;
        logic [THRESH_BITS-1:0] match_margin;
        logic [SPEED_BITS-1:0]  drive_speed;
        logic [TICK_BITS-1:0]   turn_ticks;
        logic [TICK_BITS-1:0]   blink_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t                    mode;
        logic [TURN_CNT_BITS-1:0] turn_count;
        logic [TICK_BITS-1:0]     blink_count;
        logic                     led_on;
    } state_t;

    typedef struct packed {
        logic signed [POWER_BITS-1:0] left_power;
        logic signed [POWER_BITS-1:0] right_power;
        logic                         back_led;
        mode_t                        mode;
    } result_t;

endpackage

/* src/lfmc_tick.sv */
// Single-pass tick logic: black detect, steering, mode and counter update.
module lfmc_tick
(
    input  lfmc_pkg::cfg_t                 cfg,
    input  lfmc_pkg::state_t               state,
    input  logic [lfmc_pkg::SAMPLE_BITS-1:0] left_sample,
    input  logic [lfmc_pkg::SAMPLE_BITS-1:0] right_sample,
    output lfmc_pkg::state_t               state_next,
    output lfmc_pkg::result_t              result
);

    logic [lfmc_pkg::CMP_BITS-1:0]        l_ext;
    logic [lfmc_pkg::CMP_BITS-1:0]        r_ext;
    logic [lfmc_pkg::CMP_BITS-1:0]        black_ext;
    logic [lfmc_pkg::CMP_BITS-1:0]        same_ext;
    logic [lfmc_pkg::CMP_BITS-1:0]        diff;
    logic                                 black;
    logic signed [lfmc_pkg::POWER_BITS-1:0] pwr_pos;
    logic signed [lfmc_pkg::POWER_BITS-1:0] pwr_neg;
    logic signed [lfmc_pkg::POWER_BITS-1:0] steer_left;
    logic signed [lfmc_pkg::POWER_BITS-1:0] steer_right;
    logic [lfmc_pkg::TURN_CNT_BITS-1:0]   limit_left;
    logic [lfmc_pkg::TURN_CNT_BITS-1:0]   limit_right;
    logic [lfmc_pkg::TICK_BITS-1:0]       limit_blink;
    logic [lfmc_pkg::TURN_CNT_BITS-1:0]   turn_inc;
    logic [lfmc_pkg::TICK_BITS-1:0]       blink_inc;

    assign l_ext     = lfmc_pkg::CMP_BITS'(left_sample);
    assign r_ext     = lfmc_pkg::CMP_BITS'(right_sample);
    assign black_ext = lfmc_pkg::CMP_BITS'(cfg.dark_level);
    assign same_ext  = lfmc_pkg::CMP_BITS'(cfg.match_margin);

    // A zero sample is invalid and never counts as black.
    assign black = (l_ext != '0) && (r_ext != '0) && ((l_ext < black_ext) || (r_ext < black_ext));
    assign diff  = (l_ext > r_ext) ? (l_ext - r_ext) : (r_ext - l_ext);

    assign pwr_pos = lfmc_pkg::POWER_BITS'(cfg.drive_speed);
    assign pwr_neg = -pwr_pos;

    // Bang-bang steering on the sensor difference.
    always_comb
    begin
        if (diff < same_ext)
        begin
            steer_left  = pwr_pos;
            steer_right = pwr_pos;
        end
        else if (l_ext < r_ext)
        begin
            steer_left  = pwr_neg;
            steer_right = pwr_pos;
        end
        else
        begin
            steer_left  = pwr_pos;
            steer_right = pwr_neg;
        end
    end

    // A zero tick count behaves as one.
    assign limit_left  = (cfg.turn_ticks == '0) ? lfmc_pkg::TURN_CNT_BITS'(1)
                                                : lfmc_pkg::TURN_CNT_BITS'(cfg.turn_ticks);
    assign limit_right = (cfg.turn_ticks == '0) ? lfmc_pkg::TURN_CNT_BITS'(1)
                                                : {cfg.turn_ticks, 1'b0};
    assign limit_blink = (cfg.blink_ticks == '0) ? lfmc_pkg::TICK_BITS'(1) : cfg.blink_ticks;
    assign turn_inc    = state.turn_count + lfmc_pkg::TURN_CNT_BITS'(1);
    assign blink_inc   = state.blink_count + lfmc_pkg::TICK_BITS'(1);

    // Next state.
    always_comb
    begin
        state_next = state;
        case (state.mode)
            lfmc_pkg::MODE_SEARCH:
            begin
                if (black)
                    state_next.mode = lfmc_pkg::MODE_FOLLOW;
            end
            lfmc_pkg::MODE_FOLLOW:
            begin
                if (!black)
                begin
                    state_next.mode       = lfmc_pkg::MODE_CHECK_LEFT;
                    state_next.turn_count = '0;
                end
            end
            lfmc_pkg::MODE_CHECK_LEFT:
            begin
                if (black)
                begin
                    state_next.mode       = lfmc_pkg::MODE_FOLLOW;
                    state_next.turn_count = '0;
                end
                else if (turn_inc >= limit_left)
                begin
                    state_next.mode       = lfmc_pkg::MODE_CHECK_RIGHT;
                    state_next.turn_count = '0;
                end
                else
                    state_next.turn_count = turn_inc;
            end
            lfmc_pkg::MODE_CHECK_RIGHT:
            begin
                if (black)
                begin
                    state_next.mode       = lfmc_pkg::MODE_FOLLOW;
                    state_next.turn_count = '0;
                end
                else if (turn_inc >= limit_right)
                begin
                    state_next.mode        = lfmc_pkg::MODE_DONE;
                    state_next.turn_count  = '0;
                    state_next.led_on      = 1'b1;
                    state_next.blink_count = '0;
                end
                else
                    state_next.turn_count = turn_inc;
            end
            lfmc_pkg::MODE_DONE:
            begin
                if (blink_inc >= limit_blink)
                begin
                    state_next.blink_count = '0;
                    state_next.led_on      = !state.led_on;
                end
                else
                    state_next.blink_count = blink_inc;
            end
            default:
            begin
                // Unused codes fall back to search, or to follow when black.
                state_next.mode = black ? lfmc_pkg::MODE_FOLLOW : lfmc_pkg::MODE_SEARCH;
            end
        endcase
    end

    // Motor powers.
    always_comb
    begin
        result.left_power  = '0;
        result.right_power = '0;
        case (state.mode)
            lfmc_pkg::MODE_FOLLOW:
            begin
                result.left_power  = steer_left;
                result.right_power = steer_right;
            end
            lfmc_pkg::MODE_CHECK_RIGHT:
            begin
                result.left_power  = black ? steer_left  : pwr_pos;
                result.right_power = black ? steer_right : pwr_neg;
            end
            lfmc_pkg::MODE_DONE:
            begin
                result.left_power  = '0;
                result.right_power = '0;
            end
            default:
            begin
                // Search, check left and unused codes spin left unless black.
                result.left_power  = black ? steer_left  : pwr_neg;
                result.right_power = black ? steer_right : pwr_pos;
            end
        endcase
        result.mode     = state_next.mode;
        result.back_led = (state_next.mode == lfmc_pkg::MODE_DONE) ? state_next.led_on : 1'b0;
    end

endmodule

/* src/line_follower_mode_controller.sv */
// Top level of the two-sensor bang-bang line follower mode controller.
//
// Each input transaction is one control tick with a left and a right line-sensor
// sample; each tick yields exactly one result transaction with the two signed motor
// powers, the back LED bit and the mode after the tick. The block sustains one
// transaction per clock cycle while the output side is not stalled: a tick is
// captured in an input register, passes the single-pass tick logic (black detection,
// steering, mode and counter update) and lands in the result register, where the
// result is presented until the output side takes it. The input register keeps
// taking ticks while a result waits to be taken, so a stall on the output side only
// backs up once both registers hold a transaction. Configuration registers are
// written through cfg_we / cfg_idx / cfg_wdata; the user must write them only while
// no tick is in flight, which the block itself does not enforce. Writes to indexes
// beyond the register list are ignored. After reset the controller is in search
// mode with the documented register defaults.
module line_follower_mode_controller
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [lfmc_pkg::CFG_INDEX_BITS-1:0]    cfg_idx,
    input  logic [lfmc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [lfmc_pkg::SAMPLE_BITS-1:0]       left_sample,
    input  logic [lfmc_pkg::SAMPLE_BITS-1:0]       right_sample,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [lfmc_pkg::POWER_BITS-1:0] left_power,
    output logic signed [lfmc_pkg::POWER_BITS-1:0] right_power,
    output logic                                   back_led,
    output logic [lfmc_pkg::MODE_BITS-1:0]         mode
);

`include "line_follower_mode_controller_assert.svh"

    lfmc_pkg::cfg_t    cfg_reg;
    lfmc_pkg::state_t  state_reg;
    lfmc_pkg::state_t  state_next;
    lfmc_pkg::result_t result_reg;
    lfmc_pkg::result_t result_next;

    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic [lfmc_pkg::SAMPLE_BITS-1:0] left_reg;
    logic [lfmc_pkg::SAMPLE_BITS-1:0] right_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             in_xfer;
    logic                             advance;

    // Configuration registers: write by index, ignore unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_level   <= lfmc_pkg::DARK_LEVEL_RST;
            cfg_reg.match_margin <= lfmc_pkg::MATCH_MARGIN_RST;
            cfg_reg.drive_speed  <= lfmc_pkg::DRIVE_SPEED_RST;
            cfg_reg.turn_ticks   <= lfmc_pkg::TURN_TICKS_RST;
            cfg_reg.blink_ticks  <= lfmc_pkg::BLINK_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                lfmc_pkg::CFG_DARK_LEVEL:
                    cfg_reg.dark_level <= lfmc_pkg::THRESH_BITS'(cfg_wdata);
                lfmc_pkg::CFG_MATCH_MARGIN:
                    cfg_reg.match_margin <= lfmc_pkg::THRESH_BITS'(cfg_wdata);
                lfmc_pkg::CFG_DRIVE_SPEED:
                    cfg_reg.drive_speed <= lfmc_pkg::SPEED_BITS'(cfg_wdata);
                lfmc_pkg::CFG_TURN_TICKS:
                    cfg_reg.turn_ticks <= lfmc_pkg::TICK_BITS'(cfg_wdata);
                lfmc_pkg::CFG_BLINK_TICKS:
                    cfg_reg.blink_ticks <= lfmc_pkg::TICK_BITS'(cfg_wdata);
                default:
                    ;
            endcase
        end
    end

    // Handshake: advance the captured tick whenever the result register is free
    // or being drained this cycle; take a new tick whenever the input register
    // is free or advancing.
    assign advance        = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !s1_valid_reg || advance;
    assign in_xfer        = in_valid && in_ready;
    assign s1_valid_next  = in_xfer || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register: hold samples until the tick advances.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
        end
    end

    lfmc_tick u_tick
    (
        .cfg          (cfg_reg),
        .state        (state_reg),
        .left_sample  (left_reg),
        .right_sample (right_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    // Controller state commits together with the result it produced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= lfmc_pkg::MODE_SEARCH;
            state_reg.turn_count  <= '0;
            state_reg.blink_count <= '0;
            state_reg.led_on      <= 1'b0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign left_power  = result_reg.left_power;
    assign right_power = result_reg.right_power;
    assign back_led    = result_reg.back_led;
    assign mode        = result_reg.mode;

    // A captured tick that cannot advance keeps its samples.
    `LFMC_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !advance, s1_valid_reg && $stable(left_reg) && $stable(right_reg))
    // Every advancing tick produces a result.
    `LFMC_ASSERT_NEXT(a_result_after_advance, advance, out_valid_reg)
    // The shown mode always matches the committed controller state.
    `LFMC_ASSERT_SAME(a_mode_matches_state, out_valid_reg, result_reg.mode == state_reg.mode)
    // Done is final.
    `LFMC_ASSERT_NEXT(a_done_sticky, state_reg.mode == lfmc_pkg::MODE_DONE, state_reg.mode == lfmc_pkg::MODE_DONE)
    // Search leaves only toward follow.
    `LFMC_ASSERT_NEXT(a_search_exit, advance && state_reg.mode == lfmc_pkg::MODE_SEARCH, state_reg.mode == lfmc_pkg::MODE_SEARCH || state_reg.mode == lfmc_pkg::MODE_FOLLOW)

endmodule
